// ----- rtl/core/tbcf_pkg.sv -----
// Shared types, constants and register codes for the tactile baseline
// compensation framer. No dependencies.

package tbcf_pkg;

	// Sensor geometry
	localparam int TBCF_PATCHES  = 16;
	localparam int CHANNELS      = 12;
	localparam logic [3:0] CHAN_LIMIT = 4'(CHANNELS);
	localparam logic [3:0] LAST_CHAN  = 4'(CHANNELS - 1);

	// Frame constants
	localparam logic [10:0] ID_BASE     = 11'h300;
	localparam logic [7:0]  HEAD_FIRST  = 8'h40;
	localparam logic [7:0]  HEAD_SECOND = 8'hC0;
	localparam logic [3:0]  LEN_FIRST   = 4'd8;
	localparam logic [3:0]  LEN_SECOND  = 4'd6;
	localparam logic [3:0]  LEN_FAULT   = 4'd0;

	// Input opcodes
	localparam logic OP_MEASURE = 1'b0;
	localparam logic OP_CAPTURE = 1'b1;

	// Configuration register indexes
	typedef enum logic [2:0] {
		CFG_BOARD_ADDRESS = 3'd0,
		CFG_SHIFT         = 3'd1,
		CFG_NO_LOAD       = 3'd2,
		CFG_MAX_VALUE     = 3'd3,
		CFG_MIN_VALUE     = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [3:0] board_address;
		logic [3:0] shift;
		logic [7:0] no_load;
		logic [7:0] max_value;
		logic [7:0] min_value;
	} cfg_t;

	// Measure after the difference and limit compare stage
	typedef struct packed {
		logic [3:0]  patch;
		logic [3:0]  channel;
		logic [16:0] diff;     // two's complement sample minus baseline
		logic        ge_bot;   // at or above the lower-pressure limit
		logic        le_negup; // at or below the upper-pressure limit
		logic        flt;      // zero reading against a nonzero baseline
	} meas_t;

	// One patch's results, handed to the output sequencer
	typedef struct packed {
		logic [10:0] id;
		logic        fault;
		logic [15:0] total;
		logic [63:0] p1;
		logic [63:0] p2;
	} res_t;

endpackage

// ----- rtl/core/tbcf_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.

module tbcf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/core/tbcf_framer.sv -----
// Pressure byte, pending byte buffer, fault tracking and frame assembly.
// Depends on tbcf_pkg.

module tbcf_framer
	import tbcf_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  adv,
	input  logic  s2_valid,
	input  meas_t s2,
	input  cfg_t  cfg,
	output logic  emit,
	output res_t  res
);

	logic [7:0]  pend_q [CHANNELS];
	logic [7:0]  pend_nx [CHANNELS];
	logic        patch_fault_q;
	logic        patch_fault_nx;
	logic [15:0] fault_cnt_q;
	logic [15:0] fault_cnt_nx;
	logic [16:0] quot;
	logic [7:0]  byte_val;
	logic        fire;

	assign fire = s2_valid && adv;
	assign emit = s2_valid && (s2.channel == LAST_CHAN);

	// Saturate outside the limits, else no_load minus the floored quotient
	always_comb begin
		quot = 17'($signed(s2.diff) >>> cfg.shift);
		if (s2.ge_bot) begin
			byte_val = cfg.min_value;
		end else if (s2.le_negup) begin
			byte_val = cfg.max_value;
		end else begin
			byte_val = cfg.no_load - quot[7:0];
		end
	end

	// Bypass the byte being written so the final channel lands in its frame
	always_comb begin
		for (int i = 0; i < CHANNELS; i++) begin
			pend_nx[i] = pend_q[i];
		end
		pend_nx[s2.channel] = byte_val;
	end

	assign patch_fault_nx = patch_fault_q || s2.flt;
	assign fault_cnt_nx   = s2.flt ? (fault_cnt_q + 16'd1) : fault_cnt_q;

	// Assemble both frames from the updated buffer
	always_comb begin
		res.id    = ID_BASE | {3'b000, cfg.board_address, s2.patch};
		res.fault = patch_fault_nx;
		res.total = fault_cnt_nx;
		res.p1    = {pend_nx[6], pend_nx[5], pend_nx[4], pend_nx[3],
			pend_nx[2], pend_nx[1], pend_nx[0], HEAD_FIRST};
		res.p2    = {16'h0000, pend_nx[11], pend_nx[10], pend_nx[9],
			pend_nx[8], pend_nx[7], HEAD_SECOND};
	end

	// Store the byte; no reset, so unwritten entries keep stale bytes
	always_ff @(posedge clk) begin
		if (fire) begin
			pend_q[s2.channel] <= byte_val;
		end
	end

	// Track the patch fault and count faulty readings
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			patch_fault_q <= 1'b0;
			fault_cnt_q   <= 16'd0;
		end else if (fire) begin
			patch_fault_q <= emit ? 1'b0 : patch_fault_nx;
			fault_cnt_q   <= fault_cnt_nx;
		end
	end

endmodule

// ----- rtl/core/tbcf_out.sv -----
// Output register and sequencer: one fault result or two frames per patch.
// Depends on tbcf_pkg.

module tbcf_out
	import tbcf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  res_t        res,
	output logic        free,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [10:0] frame_id,
	output logic [3:0]  frame_length,
	output logic [63:0] payload,
	output logic        fault,
	output logic [15:0] fault_total,
	output logic        last
);

	res_t res_q;
	logic valid_q;
	logic second_q;
	logic fire;

	assign fire = valid_q && !out_stall;
	assign free = !valid_q || (fire && last);

	// Present the held transaction
	always_comb begin
		out_valid   = valid_q;
		frame_id    = res_q.id;
		fault       = res_q.fault;
		fault_total = res_q.total;
		last        = res_q.fault || second_q;
		if (res_q.fault) begin
			frame_length = LEN_FAULT;
			payload      = 64'd0;
		end else if (second_q) begin
			frame_length = LEN_SECOND;
			payload      = res_q.p2;
		end else begin
			frame_length = LEN_FIRST;
			payload      = res_q.p1;
		end
	end

	// Hold results until taken
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	// Advance from the first frame to the second, drop when the last is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			second_q <= 1'b0;
		end else if (load) begin
			valid_q  <= 1'b1;
			second_q <= 1'b0;
		end else if (fire) begin
			if (last) begin
				valid_q <= 1'b0;
			end else begin
				second_q <= 1'b1;
			end
		end
	end

endmodule

// ----- rtl/core/tactile_baseline_compensation_framer_unit.sv -----
// Top level of the tactile baseline compensation framer.
// Depends on tbcf_pkg, tbcf_ram, tbcf_framer and tbcf_out.

// The unit accepts one sample per clock unless it stalls. A capture writes
// the baseline RAM in the cycle it is accepted; a measure reads its baseline
// through the RAM's registered read port, forms the difference and limit
// compares in the next cycle and the pressure byte from the stage 2 registers,
// so a final channel's results pass the RAM read and stage 1 registers, the
// stage 2 registers and then the output register. The baseline RAM has one
// valid flop per entry, cleared by reset, so no clearing pass is needed and
// samples are taken from the first cycle after reset. The output register
// holds one patch's results and loads the next as its last frame is taken; a
// final channel that finds them still waiting stalls the whole pipeline and
// the input until the output is free. Configuration writes are always ready.

module tactile_baseline_compensation_framer_unit
	import tbcf_pkg::*;
#(
	parameter int PATCHES = TBCF_PATCHES
) (
	input  logic        clk,
	input  logic        arst_n,
	// Sample channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        opcode,
	input  logic [3:0]  patch,
	input  logic [3:0]  channel,
	input  logic [15:0] raw_sample,
	// Result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [10:0] frame_id,
	output logic [3:0]  frame_length,
	output logic [63:0] payload,
	output logic        fault,
	output logic [15:0] fault_total,
	output logic        last,
	// Configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	localparam int DEPTH  = PATCHES * CHANNELS;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam logic [4:0] PATCH_LIMIT = 5'(PATCHES);

	cfg_t              cfg_q;
	logic              adv;
	logic              acc;
	logic              in_range;
	logic              acc_meas;
	logic              acc_cap;
	logic [7:0]        addr_full;
	logic [ADDR_W-1:0] addr;
	logic [DEPTH-1:0]  bvalid_q;
	logic [15:0]       rd_data;

	logic              s1_valid;
	logic [3:0]        s1_patch;
	logic [3:0]        s1_channel;
	logic [15:0]       s1_sample;
	logic              s1_bval;

	logic [15:0]       base;
	logic [16:0]       diff;
	logic [25:0]       diff_x;
	logic [25:0]       bot;
	logic [8:0]        span;
	logic [25:0]       up;
	logic [25:0]       low_sum;
	meas_t             s1_meas;

	logic              s2_valid;
	meas_t             s2_q;

	logic              emit;
	res_t              res;
	logic              out_free;

	// Hold the whole pipeline while a patch's results wait for the output
	assign adv      = !(s2_valid && emit && !out_free);
	assign in_stall = !adv;
	assign acc      = in_valid && adv;

	// Drop samples outside the table
	assign in_range = ({1'b0, patch} < PATCH_LIMIT) && (channel < CHAN_LIMIT);
	assign acc_meas = acc && in_range && (opcode == OP_MEASURE);
	assign acc_cap  = acc && in_range && (opcode == OP_CAPTURE);

	// Entry address: patch * 12 + channel
	assign addr_full = {1'b0, patch, 3'b000} + {2'b00, patch, 2'b00} + {4'b0000, channel};
	assign addr      = addr_full[ADDR_W-1:0];

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.board_address <= 4'd5;
			cfg_q.shift         <= 4'd2;
			cfg_q.no_load       <= 8'd235;
			cfg_q.max_value     <= 8'd255;
			cfg_q.min_value     <= 8'd0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_BOARD_ADDRESS: cfg_q.board_address <= cfg_data[3:0];
				CFG_SHIFT:         cfg_q.shift         <= cfg_data[3:0];
				CFG_NO_LOAD:       cfg_q.no_load       <= cfg_data;
				CFG_MAX_VALUE:     cfg_q.max_value     <= cfg_data;
				CFG_MIN_VALUE:     cfg_q.min_value     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Baseline RAM: capture writes at accept, measure reads at accept
	tbcf_ram #(
		.WIDTH(16),
		.DEPTH(DEPTH)
	) u_base_ram (
		.clk  (clk),
		.we   (acc_cap),
		.waddr(addr),
		.wdata(raw_sample),
		.re   (acc_meas),
		.raddr(addr),
		.rdata(rd_data)
	);

	// Mark written entries; unwritten ones read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bvalid_q <= '0;
		end else if (acc_cap) begin
			bvalid_q[addr] <= 1'b1;
		end
	end

	// Stage 1 registers, alongside the RAM read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (adv) begin
			s1_valid <= acc_meas;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_meas) begin
			s1_patch   <= patch;
			s1_channel <= channel;
			s1_sample  <= raw_sample;
			s1_bval    <= bvalid_q[addr];
		end
	end

	// Difference and limit compares
	always_comb begin
		base    = s1_bval ? rd_data : 16'd0;
		diff    = {1'b0, s1_sample} - {1'b0, base};
		diff_x  = {{9{diff[16]}}, diff};
		bot     = {18'd0, cfg_q.no_load} << cfg_q.shift;
		span    = {1'b0, cfg_q.max_value} - {1'b0, cfg_q.no_load};
		up      = {{17{span[8]}}, span} << cfg_q.shift;
		low_sum = diff_x + up;

		s1_meas.patch    = s1_patch;
		s1_meas.channel  = s1_channel;
		s1_meas.diff     = diff;
		s1_meas.ge_bot   = $signed(diff_x) >= $signed(bot);
		s1_meas.le_negup = $signed(low_sum) <= $signed(26'd0);
		s1_meas.flt      = (base != 16'd0) && (s1_sample == 16'd0);
	end

	// Stage 2 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid <= 1'b0;
		end else if (adv) begin
			s2_valid <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && s1_valid) begin
			s2_q <= s1_meas;
		end
	end

	tbcf_framer u_framer (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.s2_valid(s2_valid),
		.s2      (s2_q),
		.cfg     (cfg_q),
		.emit    (emit),
		.res     (res)
	);

	tbcf_out u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (s2_valid && emit && adv),
		.res         (res),
		.free        (out_free),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.frame_id    (frame_id),
		.frame_length(frame_length),
		.payload     (payload),
		.fault       (fault),
		.fault_total (fault_total),
		.last        (last)
	);

endmodule

// ----- rtl/core/tbcf_checker.sv -----
// Port-level checker for the tactile baseline compensation framer, bound
// to the top level. Depends on tbcf_pkg.

module tbcf_checker
	import tbcf_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [10:0] frame_id,
	input logic [3:0]  frame_length,
	input logic [63:0] payload,
	input logic        fault,
	input logic        last
);

	// A fault result stands alone and carries nothing
	a_fault_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fault |-> last && frame_length == LEN_FAULT && payload == 64'd0)
		else $error("fault result malformed");

	// A non-final result is always the first frame
	a_first_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> frame_length == LEN_FIRST && payload[7:0] == HEAD_FIRST)
		else $error("first frame malformed");

	// The second frame follows at once with the same identifier
	a_second_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> out_valid && last &&
		frame_id == $past(frame_id) && frame_length == LEN_SECOND &&
		payload[7:0] == HEAD_SECOND && payload[63:48] == 16'h0000)
		else $error("second frame missing or malformed");

	// A stalled transaction holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(payload) && $stable(frame_id))
		else $error("stalled result changed");

endmodule

bind tactile_baseline_compensation_framer_unit tbcf_checker u_tbcf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.frame_id    (frame_id),
	.frame_length(frame_length),
	.payload     (payload),
	.fault       (fault),
	.last        (last)
);

// ----- bench/tb_tactile_baseline_compensation_framer_unit.sv -----
`timescale 1ns / 1ps
// Self-checking bench for tactile_baseline_compensation_framer_unit: a queued sample driver,
// a frame monitor and a baseline compensation predictor. Depends on tbcf_pkg and the unit.

module tb_tactile_baseline_compensation_framer_unit;
	import tbcf_pkg::*;

	localparam int PATCHES = TBCF_PATCHES;
	localparam int RUN_LIMIT_NS = 20_000_000;
	localparam int SETTLE_CYCLES = 8;
	localparam int CHUNK_SAMPLES = 225;

	typedef struct packed {
		logic       op;
		logic [3:0] patch_idx;
		logic [3:0] chan;
		logic [15:0] raw;
	} sample_t;

	typedef struct packed {
		logic [10:0] id;
		logic [3:0]  len;
		logic [63:0] data;
		logic        flt;
		logic [15:0] total;
		logic        fin;
	} frame_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        opcode = OP_MEASURE;
	logic [3:0]  patch = '0;
	logic [3:0]  channel = '0;
	logic [15:0] raw_sample = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [10:0] frame_id;
	logic [3:0]  frame_length;
	logic [63:0] payload;
	logic        fault;
	logic [15:0] fault_total;
	logic        last;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = CFG_BOARD_ADDRESS;
	logic [7:0]  cfg_data = '0;

	// Predictor state: baselines, pending pressure bytes, fault tracking, registers
	logic [15:0] baseline_mem [PATCHES*CHANNELS];
	logic [7:0]  pending_mem [CHANNELS];
	logic        patch_faulted;
	logic [15:0] fault_count;
	cfg_t        cfg_m;

	// Stimulus side shadow of the baselines, updated as captures are queued
	logic [15:0] queued_base [PATCHES][CHANNELS];

	sample_t     sample_q[$];
	frame_t      frames_due[$];
	int unsigned samples_queued = 0;
	int unsigned samples_accepted = 0;
	int unsigned live_samples = 0;
	int unsigned frames_checked = 0;
	int unsigned fault_frames = 0;
	int unsigned mismatches = 0;
	int unsigned settings_used = 1;
	int unsigned sender_gap = 0;
	int unsigned receiver_hold = 0;
	bit          pace_sender = 1'b1;
	bit          pace_receiver = 1'b1;

	tactile_baseline_compensation_framer_unit #(.PATCHES(PATCHES)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.patch(patch),
		.channel(channel),
		.raw_sample(raw_sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.frame_id(frame_id),
		.frame_length(frame_length),
		.payload(payload),
		.fault(fault),
		.fault_total(fault_total),
		.last(last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Idle length: mostly none or short, now and then long
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Pressure byte for one measured sample against its baseline
	function automatic logic [7:0] pressure_byte(logic [15:0] smp, logic [15:0] base);
		longint s, b, d, nl, mx, pw, up, bot, q, r;
		s = smp;
		b = base;
		nl = cfg_m.no_load;
		mx = cfg_m.max_value;
		d = s - b;
		pw = 1;
		pw = pw << cfg_m.shift;
		up = (mx - nl) * pw;
		bot = nl * pw;
		if (d >= bot)
			return cfg_m.min_value;
		if (d <= -up)
			return cfg_m.max_value;
		q = d >>> cfg_m.shift;
		r = nl - q;
		return r[7:0];
	endfunction

	// Apply one accepted sample to the predictor and queue the frames it causes
	function automatic void compensate_and_frame(logic op, logic [3:0] p, logic [3:0] ch,
			logic [15:0] raw);
		int idx;
		logic [10:0] id;
		logic [63:0] p1, p2;
		if (p >= PATCHES || ch >= CHANNELS)
			return;
		idx = int'(p) * CHANNELS + int'(ch);
		if (op == OP_CAPTURE) begin
			baseline_mem[idx] = raw;
			return;
		end
		if (baseline_mem[idx] != '0 && raw == '0) begin
			patch_faulted = 1'b1;
			fault_count = fault_count + 16'd1;
		end
		pending_mem[ch] = pressure_byte(raw, baseline_mem[idx]);
		if (ch != LAST_CHAN)
			return;
		id = ID_BASE | 11'({cfg_m.board_address, p});
		if (patch_faulted) begin
			patch_faulted = 1'b0;
			frames_due.push_back('{id, LEN_FAULT, 64'd0, 1'b1, fault_count, 1'b1});
			return;
		end
		p1 = {56'd0, HEAD_FIRST};
		for (int i = 0; i < 7; i++)
			p1[8*(i+1) +: 8] = pending_mem[i];
		p2 = {56'd0, HEAD_SECOND};
		for (int i = 0; i < 5; i++)
			p2[8*(i+1) +: 8] = pending_mem[7+i];
		frames_due.push_back('{id, LEN_FIRST, p1, 1'b0, fault_count, 1'b0});
		frames_due.push_back('{id, LEN_SECOND, p2, 1'b0, fault_count, 1'b1});
	endfunction

	// Sample driver: present the next queued sample, hold it while stalled
	always @(posedge clk or negedge arst_n) begin
		sample_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			sender_gap = 0;
		end else begin
			if (in_valid && !in_stall) begin
				compensate_and_frame(opcode, patch, channel, raw_sample);
				samples_accepted++;
			end
			if (!in_valid || !in_stall) begin
				if (sender_gap > 0) begin
					sender_gap--;
					in_valid <= 1'b0;
				end else if (sample_q.size() > 0) begin
					nxt = sample_q.pop_front();
					opcode <= nxt.op;
					patch <= nxt.patch_idx;
					channel <= nxt.chan;
					raw_sample <= nxt.raw;
					in_valid <= 1'b1;
					sender_gap = pace_sender ? idle_len() : 0;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Frame monitor: check each accepted frame, then pick the next stall
	always @(posedge clk or negedge arst_n) begin
		frame_t exp_f;
		if (!arst_n) begin
			out_stall <= 1'b0;
			receiver_hold = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (frames_due.size() == 0) begin
					$error("unexpected frame: frame_id %h frame_length %0d", frame_id,
						frame_length);
					mismatches++;
				end else begin
					exp_f = frames_due.pop_front();
					frames_checked++;
					if (exp_f.flt)
						fault_frames++;
					if (frame_id !== exp_f.id) begin
						$error("frame_id expected %h actual %h", exp_f.id, frame_id);
						mismatches++;
					end
					if (frame_length !== exp_f.len) begin
						$error("frame_length expected %0d actual %0d", exp_f.len, frame_length);
						mismatches++;
					end
					if (payload !== exp_f.data) begin
						$error("payload expected %h actual %h", exp_f.data, payload);
						mismatches++;
					end
					if (fault !== exp_f.flt) begin
						$error("fault expected %b actual %b", exp_f.flt, fault);
						mismatches++;
					end
					if (fault_total !== exp_f.total) begin
						$error("fault_total expected %0d actual %0d", exp_f.total, fault_total);
						mismatches++;
					end
					if (last !== exp_f.fin) begin
						$error("last expected %b actual %b", exp_f.fin, last);
						mismatches++;
					end
				end
			end
			if (receiver_hold > 0) begin
				receiver_hold--;
				out_stall <= 1'b1;
			end else if (pace_receiver && $urandom_range(0, 99) < 30) begin
				receiver_hold = idle_len();
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic queue_sample(logic op, logic [3:0] p, logic [3:0] ch, logic [15:0] raw);
		sample_q.push_back('{op, p, ch, raw});
		samples_queued++;
		if (ch < CHANNELS) begin
			live_samples++;
			if (op == OP_CAPTURE)
				queued_base[p][ch] = raw;
		end
	endtask

	function automatic logic [15:0] pick_baseline();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return '0;
		if (r < 20)
			return 16'($urandom);
		return 16'($urandom_range(1000, 60000));
	endfunction

	// Reading close to the baseline so the byte lands inside the limits often
	function automatic logic [15:0] sample_near(logic [15:0] base);
		int unsigned r;
		int span, v;
		r = $urandom_range(0, 99);
		if (r < 5)
			return '0;
		if (r < 10)
			return 16'hFFFF;
		if (r < 15)
			return 16'($urandom);
		span = 256 << cfg_m.shift;
		if (span > 70000)
			span = 70000;
		v = int'(base) + int'($urandom_range(0, 2 * span)) - span;
		if (v < 0)
			v = 0;
		if (v > 65535)
			v = 65535;
		return 16'(v);
	endfunction

	// Mostly whole patches, some broken runs and some noise
	task automatic queue_random(int unsigned count);
		int unsigned goal, kind, first, stop;
		logic [3:0] p;
		goal = live_samples + count;
		while (live_samples < goal) begin
			kind = $urandom_range(0, 99);
			p = 4'($urandom_range(0, PATCHES - 1));
			if (kind < 20) begin
				for (int ch = 0; ch < CHANNELS; ch++)
					queue_sample(OP_CAPTURE, p, 4'(ch), pick_baseline());
			end else if (kind < 75) begin
				for (int ch = 0; ch < CHANNELS; ch++)
					queue_sample(OP_MEASURE, p, 4'(ch), sample_near(queued_base[p][ch]));
			end else if (kind < 87) begin
				first = $urandom_range(0, CHANNELS - 1);
				stop = $urandom_range(first, CHANNELS - 1);
				for (int unsigned ch = first; ch <= stop; ch++)
					queue_sample(OP_MEASURE, p, 4'(ch), sample_near(queued_base[p][ch]));
			end else begin
				queue_sample($urandom_range(0, 1) ? OP_CAPTURE : OP_MEASURE, p,
					4'($urandom_range(0, 15)), 16'($urandom));
			end
		end
	endtask

	// Wait until every sample is taken and every frame has come, then let the pipe empty
	task automatic settle();
		while (samples_accepted != samples_queued || frames_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CFG_BOARD_ADDRESS: cfg_m.board_address = val[3:0];
			CFG_SHIFT:         cfg_m.shift = val[3:0];
			CFG_NO_LOAD:       cfg_m.no_load = val;
			CFG_MAX_VALUE:     cfg_m.max_value = val;
			CFG_MIN_VALUE:     cfg_m.min_value = val;
			default: ;
		endcase
	endtask

	task automatic apply_settings(cfg_t c);
		write_reg(CFG_BOARD_ADDRESS, {4'd0, c.board_address});
		write_reg(CFG_SHIFT, {4'd0, c.shift});
		write_reg(CFG_NO_LOAD, c.no_load);
		write_reg(CFG_MAX_VALUE, c.max_value);
		write_reg(CFG_MIN_VALUE, c.min_value);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// Run limit
	initial begin
		#(RUN_LIMIT_NS);
		$display("status: fail");
		$finish;
	end

	initial begin
		cfg_t settings [5];
		for (int i = 0; i < PATCHES * CHANNELS; i++)
			baseline_mem[i] = '0;
		for (int i = 0; i < CHANNELS; i++)
			pending_mem[i] = '0;
		for (int p = 0; p < PATCHES; p++)
			for (int ch = 0; ch < CHANNELS; ch++)
				queued_base[p][ch] = '0;
		patch_faulted = 1'b0;
		fault_count = '0;
		cfg_m = '{board_address: 4'd5, shift: 4'd2, no_load: 8'd235, max_value: 8'd255,
			min_value: 8'd0};

		// Low extremes, high extremes, inverted limits, then two random settings
		settings[0] = '{4'd0, 4'd0, 8'd0, 8'd0, 8'd0};
		settings[1] = '{4'd15, 4'd15, 8'd255, 8'd255, 8'd255};
		settings[2] = '{4'd10, 4'd1, 8'd200, 8'd100, 8'd30};
		for (int i = 3; i < 5; i++)
			settings[i] = '{4'($urandom), 4'($urandom_range(0, 6)), 8'($urandom),
				8'($urandom), 8'($urandom)};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: captures incl. an out of range channel, then a faulted patch
		queue_sample(OP_CAPTURE, 4'd15, 4'd0, 16'hFFFF);
		queue_sample(OP_CAPTURE, 4'd15, 4'd1, 16'h8000);
		queue_sample(OP_CAPTURE, 4'd15, 4'd2, 16'd1000);
		queue_sample(OP_CAPTURE, 4'd15, 4'd13, 16'd1234);
		queue_sample(OP_MEASURE, 4'd15, 4'd0, 16'd0);
		queue_sample(OP_MEASURE, 4'd15, 4'd1, 16'hFFFF);
		queue_sample(OP_MEASURE, 4'd15, 4'd2, 16'd1000);
		queue_sample(OP_MEASURE, 4'd15, 4'd3, 16'd0);
		queue_sample(OP_MEASURE, 4'd15, 4'd4, 16'd939);
		queue_sample(OP_MEASURE, 4'd15, 4'd5, 16'd940);
		queue_sample(OP_MEASURE, 4'd15, 4'd6, 16'd1);
		queue_sample(OP_MEASURE, 4'd15, 4'd7, 16'hFFFF);
		queue_sample(OP_MEASURE, 4'd15, 4'd8, 16'd0);
		queue_sample(OP_MEASURE, 4'd15, 4'd9, 16'd7);
		queue_sample(OP_MEASURE, 4'd15, 4'd10, 16'd8);
		queue_sample(OP_MEASURE, 4'd15, 4'd11, 16'd0);
		queue_sample(OP_MEASURE, 4'd15, 4'd15, 16'hAAAA);
		// Lone final channel: frames from stale pending bytes, negative differences
		queue_sample(OP_CAPTURE, 4'd0, 4'd11, 16'd100);
		queue_sample(OP_MEASURE, 4'd0, 4'd11, 16'd81);
		queue_sample(OP_MEASURE, 4'd0, 4'd11, 16'd20);
		queue_random(CHUNK_SAMPLES);
		settle();

		for (int ph = 0; ph < 5; ph++) begin
			apply_settings(settings[ph]);
			pace_sender = (ph != 3);
			pace_receiver = (ph != 3);
			queue_random(CHUNK_SAMPLES);
			settle();
		end

		$display("summary: %0d samples under %0d register settings", samples_accepted,
			settings_used);
		$display("summary: %0d frames checked, %0d of them fault results", frames_checked,
			fault_frames);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/tbcf_pkg.sv
rtl/core/tbcf_ram.sv
rtl/core/tbcf_framer.sv
rtl/core/tbcf_out.sv
rtl/core/tactile_baseline_compensation_framer_unit.sv
rtl/core/tbcf_checker.sv
bench/tb_tactile_baseline_compensation_framer_unit.sv
